>>> hdl/bhpq_pkg.sv
// Shared types, constants and helpers for the binary heap priority queue.
// Used by every module of the block; depends on nothing else.

package bhpq_pkg;

  // Heap geometry and entry format.
  localparam int DEPTH      = 64;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int IDX_W      = ADDR_W + 2;

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic [CNT_W-1:0]             cnt_t;
  typedef logic [ADDR_W-1:0]            addr_t;

  // Operation codes of an input transaction.
  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_t;

  // Classified command handed from the front end to the heap engine.
  typedef struct packed {
    op_t   op;
    data_t value;
    logic  err;
    cnt_t  cnt;
  } cmd_t;

  // One result transaction.
  typedef struct packed {
    data_t top;
    cnt_t  count;
    logic  empty;
    logic  err;
  } res_t;

  // Engine status seen by the top level.
  typedef struct packed {
    logic idle;
    cnt_t count;
  } eng_status_t;

  // True when value a has to sit above value b (strict ordering).
  function automatic logic ranks_above(input data_t a, input data_t b, input logic max_mode);
    ranks_above = max_mode ? (a > b) : (a < b);
  endfunction

endpackage

>>> hdl/bhpq_front.sv
// Front end: accepts input transactions and classifies them.
// Tracks the entry count ahead of the engine; depends on bhpq_pkg.

module bhpq_front import bhpq_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  output logic  full,
  input  logic  in_opcode,
  input  data_t in_push_value,
  input  logic  cmd_full,
  output logic  cmd_wr,
  output cmd_t  cmd_data,
  output cnt_t  shadow_cnt
);

  cnt_t cnt_r;
  cnt_t cnt_nxt;
  op_t  op;
  logic err;

  // Classify the item against the count that all earlier items leave.
  always_comb begin
    op      = op_t'(in_opcode);
    err     = (op == OP_PUSH) ? (cnt_r == CNT_W'(DEPTH)) : (cnt_r == '0);
    cnt_nxt = cnt_r;
    if (!err) begin
      if (op == OP_PUSH) begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end else begin
        cnt_nxt = cnt_r - CNT_W'(1);
      end
    end
  end

  assign full               = cmd_full;
  assign cmd_wr             = push && !cmd_full;
  assign cmd_data.op        = op;
  assign cmd_data.value     = in_push_value;
  assign cmd_data.err       = err;
  assign cmd_data.cnt       = cnt_nxt;
  assign shadow_cnt         = cnt_r;

  // Count register advances on each accepted transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd_wr) begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> hdl/bhpq_cmd_queue.sv
// Two-entry command queue between the front end and the heap engine.
// Depends on bhpq_pkg for the command type.

module bhpq_cmd_queue import bhpq_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr,
  input  cmd_t wr_data,
  output logic q_full,
  input  logic rd,
  output cmd_t rd_data,
  output logic q_empty
);

  cmd_t       slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;

  assign q_full  = (cnt_r == 2'd2);
  assign q_empty = (cnt_r == 2'd0);
  assign rd_data = slot_r[rd_ptr_r];

  // Pointer and occupancy bookkeeping.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (wr) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (rd) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (wr && !rd) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (rd && !wr) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  // Payload storage needs no reset.
  always_ff @(posedge clk) begin
    if (wr) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

>>> hdl/bhpq_result_queue.sv
// Two-entry result queue that decouples the engine from the result consumer.
// Depends on bhpq_pkg for the result type.

module bhpq_result_queue import bhpq_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr,
  input  res_t wr_data,
  output logic q_full,
  input  logic rd,
  output res_t rd_data,
  output logic q_empty
);

  res_t       slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;

  assign q_full  = (cnt_r == 2'd2);
  assign q_empty = (cnt_r == 2'd0);
  assign rd_data = slot_r[rd_ptr_r];

  // Pointer and occupancy bookkeeping.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (wr) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (rd) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (wr && !rd) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (rd && !wr) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  // Payload storage needs no reset.
  always_ff @(posedge clk) begin
    if (wr) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

>>> hdl/bhpq_engine.sv
// Heap engine: owns the heap memory and runs sift-up and sift-down.
// Takes commands from the command queue, writes results; depends on bhpq_pkg.

module bhpq_engine import bhpq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        max_mode,
  input  logic        cmd_empty,
  input  cmd_t        cmd_data,
  output logic        cmd_rd,
  input  logic        res_full,
  output logic        res_wr,
  output res_t        res_data,
  output eng_status_t status
);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_UP      = 7'b0000010,
    S_DN_LOAD = 7'b0000100,
    S_DN_CHK  = 7'b0001000,
    S_DN_L    = 7'b0010000,
    S_DN_R    = 7'b0100000,
    S_DONE    = 7'b1000000
  } state_t;

  // Heap memory: one write port, one registered read port.
  data_t  mem [DEPTH];
  data_t  rd_data_r;
  logic   rd_en;
  addr_t  rd_addr;
  logic   wr_en;
  addr_t  wr_addr;
  data_t  wr_data;

  state_t state_r,    state_nxt;
  data_t  cur_r,      cur_nxt;
  addr_t  pos_r,      pos_nxt;
  cnt_t   cnt_r,      cnt_nxt;
  logic   err_r,      err_nxt;
  data_t  best_val_r, best_val_nxt;
  addr_t  best_idx_r, best_idx_nxt;
  data_t  top_r;

  logic [IDX_W-1:0] lc_w;
  logic [IDX_W-1:0] rc_w;
  addr_t            par;
  addr_t            par2;
  addr_t            push_pos;
  logic             l_above;
  logic             r_above;
  data_t            cand_val;
  addr_t            cand_idx;

  // Index arithmetic of the current position.
  always_comb begin
    lc_w     = IDX_W'({pos_r, 1'b1});
    rc_w     = lc_w + IDX_W'(1);
    par      = (pos_r - ADDR_W'(1)) >> 1;
    par2     = (par - ADDR_W'(1)) >> 1;
    push_pos = ADDR_W'(cmd_data.cnt - CNT_W'(1));
  end

  // Best of the moving entry and the children read so far.
  always_comb begin
    l_above = ranks_above(rd_data_r, cur_r, max_mode);
    r_above = ranks_above(rd_data_r, best_val_r, max_mode);
    if (state_r == S_DN_R) begin
      cand_val = r_above ? rd_data_r : best_val_r;
      cand_idx = r_above ? rc_w[ADDR_W-1:0] : best_idx_r;
    end else begin
      cand_val = l_above ? rd_data_r : cur_r;
      cand_idx = l_above ? lc_w[ADDR_W-1:0] : pos_r;
    end
  end

  // Sequencer of the sift operations.
  always_comb begin
    state_nxt    = state_r;
    cur_nxt      = cur_r;
    pos_nxt      = pos_r;
    cnt_nxt      = cnt_r;
    err_nxt      = err_r;
    best_val_nxt = best_val_r;
    best_idx_nxt = best_idx_r;
    rd_en        = 1'b0;
    rd_addr      = '0;
    wr_en        = 1'b0;
    wr_addr      = pos_r;
    wr_data      = cur_r;
    cmd_rd       = 1'b0;
    res_wr       = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (!cmd_empty) begin
          cmd_rd  = 1'b1;
          err_nxt = cmd_data.err;
          cnt_nxt = cmd_data.cnt;
          cur_nxt = cmd_data.value;
          if (cmd_data.err) begin
            state_nxt = S_DONE;
          end else if (cmd_data.op == OP_PUSH) begin
            pos_nxt = push_pos;
            if (push_pos == '0) begin
              wr_en     = 1'b1;
              wr_addr   = '0;
              wr_data   = cmd_data.value;
              state_nxt = S_DONE;
            end else begin
              rd_en     = 1'b1;
              rd_addr   = (push_pos - ADDR_W'(1)) >> 1;
              state_nxt = S_UP;
            end
          end else begin
            pos_nxt = '0;
            if (cmd_data.cnt == '0) begin
              state_nxt = S_DONE;
            end else begin
              // Fetch the last entry, which moves to the root.
              rd_en     = 1'b1;
              rd_addr   = ADDR_W'(cmd_data.cnt);
              state_nxt = S_DN_LOAD;
            end
          end
        end
      end
      S_UP: begin
        // The parent of the hole is in rd_data_r unless the hole is the root.
        wr_en = 1'b1;
        if (pos_r == '0) begin
          state_nxt = S_DONE;
        end else if (ranks_above(cur_r, rd_data_r, max_mode)) begin
          wr_data = rd_data_r;
          pos_nxt = par;
          if (par != '0) begin
            rd_en   = 1'b1;
            rd_addr = par2;
          end
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DN_LOAD: begin
        cur_nxt   = rd_data_r;
        state_nxt = S_DN_CHK;
      end
      S_DN_CHK: begin
        if (lc_w >= IDX_W'(cnt_r)) begin
          wr_en     = 1'b1;
          state_nxt = S_DONE;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = lc_w[ADDR_W-1:0];
          state_nxt = S_DN_L;
        end
      end
      S_DN_L, S_DN_R: begin
        if ((state_r == S_DN_L) && (rc_w < IDX_W'(cnt_r))) begin
          // Right child exists: fetch it and keep the running best.
          rd_en        = 1'b1;
          rd_addr      = rc_w[ADDR_W-1:0];
          best_val_nxt = cand_val;
          best_idx_nxt = cand_idx;
          state_nxt    = S_DN_R;
        end else if (cand_idx == pos_r) begin
          wr_en     = 1'b1;
          state_nxt = S_DONE;
        end else begin
          // Move the winning child up and descend into its slot.
          wr_en     = 1'b1;
          wr_data   = cand_val;
          pos_nxt   = cand_idx;
          state_nxt = S_DN_CHK;
        end
      end
      S_DONE: begin
        if (!res_full) begin
          res_wr    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Memory ports and the copy of the root entry.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
    if (wr_en && (wr_addr == '0)) begin
      top_r <= wr_data;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      err_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      err_r   <= err_nxt;
    end
  end

  // Working registers of the sift.
  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    pos_r      <= pos_nxt;
    best_val_r <= best_val_nxt;
    best_idx_r <= best_idx_nxt;
  end

  assign res_data.top   = (cnt_r == '0) ? '0 : top_r;
  assign res_data.count = cnt_r;
  assign res_data.empty = (cnt_r == '0);
  assign res_data.err   = err_r;
  assign status.idle    = (state_r == S_IDLE);
  assign status.count   = cnt_r;

endmodule

>>> hdl/binary_heap_priority_queue.sv
// Top level of the binary heap priority queue: front end, command queue,
// heap engine and result queue; depends on bhpq_pkg and those modules.
//
//   Channel   Handshake                  Payload
//   input     push / full                in_opcode, in_push_value
//   result    pop / empty                out_top_value, out_entry_count,
//                                        out_is_empty, out_op_error
//   config    cfg_we                     cfg_wdata (max-heap when 1)
//
// The heap engine does one transaction at a time: a refused transaction
// goes straight to its result, a push sifts up one level per step and a
// pop sifts down, fetching children via the single read port of the heap
// memory. Reset is synchronous and active low, clears the count and sets
// max-heap mode. The command and result queues let input and result sides
// stall independently; the heap memory needs no clearing pass.

module binary_heap_priority_queue import bhpq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  output logic                  full,
  input  logic                  in_opcode,
  input  data_t                 in_push_value,
  output logic                  empty,
  input  logic                  pop,
  output data_t                 out_top_value,
  output logic [CNT_W-1:0]      out_entry_count,
  output logic                  out_is_empty,
  output logic                  out_op_error,
  input  logic                  cfg_we,
  input  logic                  cfg_wdata
);

  logic        max_mode_r;
  logic        cmd_wr;
  cmd_t        cmd_wr_data;
  logic        cmd_full;
  logic        cmd_rd;
  cmd_t        cmd_rd_data;
  logic        cmd_empty;
  cnt_t        shadow_cnt;
  logic        res_wr;
  res_t        res_wr_data;
  logic        res_full;
  res_t        res_rd_data;
  eng_status_t status;

  // Mode register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_mode_r <= 1'b1;
    end else if (cfg_we) begin
      max_mode_r <= cfg_wdata;
    end
  end

  bhpq_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_opcode     (in_opcode),
    .in_push_value (in_push_value),
    .cmd_full      (cmd_full),
    .cmd_wr        (cmd_wr),
    .cmd_data      (cmd_wr_data),
    .shadow_cnt    (shadow_cnt)
  );

  bhpq_cmd_queue u_cmd_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (cmd_wr),
    .wr_data (cmd_wr_data),
    .q_full  (cmd_full),
    .rd      (cmd_rd),
    .rd_data (cmd_rd_data),
    .q_empty (cmd_empty)
  );

  bhpq_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .max_mode  (max_mode_r),
    .cmd_empty (cmd_empty),
    .cmd_data  (cmd_rd_data),
    .cmd_rd    (cmd_rd),
    .res_full  (res_full),
    .res_wr    (res_wr),
    .res_data  (res_wr_data),
    .status    (status)
  );

  bhpq_result_queue u_result_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (res_wr),
    .wr_data (res_wr_data),
    .q_full  (res_full),
    .rd      (pop && !empty),
    .rd_data (res_rd_data),
    .q_empty (empty)
  );

  assign out_top_value   = res_rd_data.top;
  assign out_entry_count = res_rd_data.count;
  assign out_is_empty    = res_rd_data.empty;
  assign out_op_error    = res_rd_data.err;

  // The engine never writes a result into a full result queue.
  a_no_result_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_wr |-> !res_full)
    else $error("result written into full result queue");

  // A waiting result reports empty exactly when its count is zero.
  a_empty_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_is_empty == (out_entry_count == '0)))
    else $error("empty flag disagrees with entry count");

  // A waiting result never reports more entries than the heap holds.
  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_entry_count <= CNT_W'(DEPTH)))
    else $error("entry count beyond heap depth");

  // Once all commands are done, front and engine agree on the count.
  a_count_tracking: assert property (@(posedge clk) disable iff (!rst_n)
    (status.idle && cmd_empty) |-> (shadow_cnt == status.count))
    else $error("front end count differs from engine count");

endmodule
